FILE: rtl/lzo_pkg.sv
package lzo_pkg;

  localparam int MAX_LAYERS  = 8;
  localparam int IDX_W       = $clog2(MAX_LAYERS);
  localparam int TOTAL_W     = IDX_W + 1;
  localparam int FIELD_IDX_W = 3;
  localparam int CMP_W       = (FIELD_IDX_W > TOTAL_W) ? FIELD_IDX_W : TOTAL_W;
  localparam int DEPTH_W     = 11;
  localparam int CNT_W       = $clog2(2 * MAX_LAYERS + 1);

  localparam logic signed [DEPTH_W-1:0] DEPTH_MIN = -11'sd1000;
  localparam logic signed [DEPTH_W-1:0] DEPTH_MAX = 11'sd1000;

  localparam logic [2:0] KIND_CLEAR    = 3'd0;
  localparam logic [2:0] KIND_APPEND   = 3'd1;
  localparam logic [2:0] KIND_SHOW     = 3'd2;
  localparam logic [2:0] KIND_HIDE     = 3'd3;
  localparam logic [2:0] KIND_HIDE_ALL = 3'd4;
  localparam logic [2:0] KIND_PAINT    = 3'd5;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [1:0] STAT_FULL      = 2'd2;

  // one entry moving through the sort chain
  typedef struct packed {
    logic                      valid;
    logic [IDX_W-1:0]          idx;
    logic signed [DEPTH_W-1:0] depth;
  } sort_ent_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic shift;
  } cell_ctrl_t;

  typedef struct packed {
    logic                      en;
    logic [2:0]                kind;
    logic [FIELD_IDX_W-1:0]    idx;
    logic signed [DEPTH_W-1:0] depth;
    logic                      use_ovr;
    logic                      pz;
    logic                      cz;
  } lzo_cmd_t;

  function automatic logic signed [DEPTH_W-1:0] clamp_depth(
    input logic signed [DEPTH_W-1:0] d
  );
    logic signed [DEPTH_W-1:0] r;
    r = d;
    if (d < DEPTH_MIN) r = DEPTH_MIN;
    if (d > DEPTH_MAX) r = DEPTH_MAX;
    return r;
  endfunction

endpackage

FILE: rtl/lzo_cell.sv
module lzo_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lzo_pkg::cell_ctrl_t  ctrl,
  input  lzo_pkg::sort_ent_t   left_in,
  input  lzo_pkg::sort_ent_t   right_in,
  output lzo_pkg::sort_ent_t   held,
  output lzo_pkg::sort_ent_t   fwd
);
  import lzo_pkg::*;

  sort_ent_t held_r, fwd_r;
  sort_ent_t held_nxt, fwd_nxt;

  always_comb begin
    held_nxt       = held_r;
    fwd_nxt        = fwd_r;
    fwd_nxt.valid  = 1'b0;
    if (ctrl.clear) begin
      held_nxt.valid = 1'b0;
    end else if (ctrl.shift) begin
      held_nxt = right_in;
    end else if (ctrl.load && left_in.valid) begin
      if (!held_r.valid) begin
        held_nxt = left_in;
      end else if (($signed(left_in.depth) < $signed(held_r.depth)) ||
                   ((left_in.depth == held_r.depth) && (left_in.idx < held_r.idx))) begin
        // equal depths go by table index, so a displaced entry keeps table order
        held_nxt = left_in;
        fwd_nxt  = held_r;
      end else begin
        fwd_nxt = left_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
      fwd_r  <= '0;
    end else begin
      held_r <= held_nxt;
      fwd_r  <= fwd_nxt;
    end
  end

  assign held = held_r;
  assign fwd  = fwd_r;

endmodule

FILE: rtl/lzo_table.sv
module lzo_table (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lzo_pkg::lzo_cmd_t             cmd,
  input  logic [lzo_pkg::IDX_W-1:0]     scan_idx,
  output lzo_pkg::sort_ent_t            scan_ent,
  output logic [1:0]                    status,
  output logic                          any_pauses,
  output logic                          any_captures
);
  import lzo_pkg::*;

  logic [TOTAL_W-1:0]        total_r;
  logic [MAX_LAYERS-1:0]     shown_r;
  logic [MAX_LAYERS-1:0]     ovr_on_r;
  logic [MAX_LAYERS-1:0]     pause_r;
  logic [MAX_LAYERS-1:0]     capt_r;
  logic signed [DEPTH_W-1:0] ovr_depth_r [MAX_LAYERS];
  logic signed [DEPTH_W-1:0] def_depth_r [MAX_LAYERS];

  logic full;
  logic hit;

  assign full = (total_r == TOTAL_W'(MAX_LAYERS));
  assign hit  = (CMP_W'(cmd.idx) < CMP_W'(total_r));

  always_comb begin
    unique case (cmd.kind) inside
      KIND_APPEND:          status = full ? STAT_FULL : STAT_OK;
      KIND_SHOW, KIND_HIDE: status = hit ? STAT_OK : STAT_NOT_FOUND;
      default:              status = STAT_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r  <= '0;
      shown_r  <= '0;
      ovr_on_r <= '0;
    end else if (cmd.en) begin
      case (cmd.kind)
        KIND_CLEAR: begin
          total_r  <= '0;
          shown_r  <= '0;
          ovr_on_r <= '0;
        end
        KIND_APPEND: begin
          if (!full) begin
            total_r <= total_r + 1'b1;
            for (int i = 0; i < MAX_LAYERS; i++) begin
              if (TOTAL_W'(i) == total_r) begin
                shown_r[i]  <= 1'b0;
                ovr_on_r[i] <= 1'b0;
              end
            end
          end
        end
        KIND_SHOW: begin
          for (int i = 0; i < MAX_LAYERS; i++) begin
            if (hit && CMP_W'(i) == CMP_W'(cmd.idx)) begin
              shown_r[i] <= 1'b1;
              if (cmd.use_ovr) ovr_on_r[i] <= 1'b1;
            end
          end
        end
        KIND_HIDE: begin
          for (int i = 0; i < MAX_LAYERS; i++) begin
            if (hit && CMP_W'(i) == CMP_W'(cmd.idx)) begin
              shown_r[i]  <= 1'b0;
              ovr_on_r[i] <= 1'b0;
            end
          end
        end
        KIND_HIDE_ALL: begin
          shown_r  <= '0;
          ovr_on_r <= '0;
        end
        default: ;
      endcase
    end
  end

  // layer payload, written on an append that fits and on a show with override
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_LAYERS; i++) begin
      if (cmd.en && cmd.kind == KIND_APPEND && !full && TOTAL_W'(i) == total_r) begin
        def_depth_r[i] <= cmd.depth;
        pause_r[i]     <= cmd.pz;
        capt_r[i]      <= cmd.cz;
      end
      if (cmd.en && cmd.kind == KIND_SHOW && cmd.use_ovr && hit &&
          CMP_W'(i) == CMP_W'(cmd.idx)) begin
        ovr_depth_r[i] <= cmd.depth;
      end
    end
  end

  assign scan_ent.valid = shown_r[scan_idx];
  assign scan_ent.idx   = scan_idx;
  assign scan_ent.depth = ovr_on_r[scan_idx] ? ovr_depth_r[scan_idx]
                                             : def_depth_r[scan_idx];

  assign any_pauses   = |(shown_r & pause_r);
  assign any_captures = |(shown_r & capt_r);

endmodule

FILE: rtl/layer_z_order_table.sv
// Channel | Dir | Signals                         | Payload
// in_     | in  | in_tvalid/in_tready             | tuser kind, tdata layer fields
// out_    | out | out_tvalid/out_tready/out_tlast | tdata one paint-order result
//
// Non-paint commands: accepted in S_IDLE, then registered into the output stage from S_RESP once it is free.
// Paint: the table is streamed through the cell row in S_LOAD and left to settle, then one
// result per cycle per visible layer while the output is not stalled (one if none visible).
// The sort latency is set by the row length: an entry may walk every cell.
// Reset is synchronous, active low; it empties the table and the output stage.
// A stalled output holds the row and the sequencer; input waits until done.
module layer_z_order_table (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [2:0]  in_tuser,   // kind
  input  logic [23:0] in_tdata,   // layer_index[2:0], depth_value[13:3],
                                  // use_override[14], scene_pause[15],
                                  // input_grab[16], zero fill
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic        out_tlast,  // last
  output logic [7:0]  out_tdata   // order_index[2:0], order_valid[3],
                                  // status[5:4], any_pauses[6], any_captures[7]
);
  import lzo_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RESP = 2'd1;
  localparam logic [1:0] S_LOAD = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]       stat_r;

  logic       out_valid_r;
  logic       out_last_r;
  logic [7:0] out_data_r;
  logic       out_load;
  logic       out_last_nxt;
  logic [7:0] out_data_nxt;
  logic       out_free;

  logic       acc;
  lzo_cmd_t   cmd;
  sort_ent_t  scan_ent;
  sort_ent_t  feed_ent;
  logic [1:0] tbl_status;
  logic       any_p, any_c;
  cell_ctrl_t ctrl;
  logic       shift_go;

  sort_ent_t held [MAX_LAYERS];
  sort_ent_t fwd  [MAX_LAYERS];

  assign in_tready = (state_r == S_IDLE);
  assign acc       = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  assign cmd.en      = acc;
  assign cmd.kind    = in_tuser;
  assign cmd.idx     = in_tdata[2:0];
  assign cmd.depth   = clamp_depth(in_tdata[13:3]);
  assign cmd.use_ovr = in_tdata[14];
  assign cmd.pz      = in_tdata[15];
  assign cmd.cz      = in_tdata[16];

  lzo_table u_table (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .scan_idx     (cnt_r[IDX_W-1:0]),
    .scan_ent     (scan_ent),
    .status       (tbl_status),
    .any_pauses   (any_p),
    .any_captures (any_c)
  );

  always_comb begin
    feed_ent       = scan_ent;
    feed_ent.valid = scan_ent.valid && (state_r == S_LOAD) &&
                     (cnt_r < CNT_W'(MAX_LAYERS));
  end

  assign shift_go   = (state_r == S_EMIT) && out_free && held[0].valid;
  assign ctrl.clear = acc && (in_tuser == KIND_PAINT);
  assign ctrl.load  = (state_r == S_LOAD);
  assign ctrl.shift = shift_go;

  for (genvar g = 0; g < MAX_LAYERS; g++) begin : g_cell
    sort_ent_t left_in, right_in;
    if (g == 0) begin : g_head
      assign left_in = feed_ent;
    end else begin : g_mid
      assign left_in = fwd[g-1];
    end
    if (g == MAX_LAYERS - 1) begin : g_tail
      assign right_in = '0;
    end else begin : g_body
      assign right_in = held[g+1];
    end
    lzo_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .left_in  (left_in),
      .right_in (right_in),
      .held     (held[g]),
      .fwd      (fwd[g])
    );
  end

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    out_load     = 1'b0;
    out_last_nxt = 1'b1;
    out_data_nxt = {any_c, any_p, stat_r, 1'b0, 3'd0};
    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          cnt_nxt   = '0;
          state_nxt = (in_tuser == KIND_PAINT) ? S_LOAD : S_RESP;
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_LOAD: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(2 * MAX_LAYERS)) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          if (held[0].valid) begin
            out_last_nxt = !held[1].valid;
            out_data_nxt = {any_c, any_p, STAT_OK, 1'b1,
                            FIELD_IDX_W'(held[0].idx)};
            if (!held[1].valid) state_nxt = S_IDLE;
          end else begin
            out_data_nxt = {any_c, any_p, STAT_OK, 1'b0, 3'd0};
            state_nxt    = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) stat_r <= tbl_status;
    if (out_load) begin
      out_last_r <= out_last_nxt;
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = out_data_r;

  // row must be settled before results go out (checked on the fwd of cell 0 and cell MAX_LAYERS-2)
  a_settled: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> !fwd[0].valid && !fwd[MAX_LAYERS-2].valid)
    else $error("sort row still moving during emit");

  a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && held[0].valid && held[1].valid) |->
      ($signed(held[0].depth) <= $signed(held[1].depth)))
    else $error("paint order out of depth order");

  a_paint_start: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_tuser == KIND_PAINT) |=> (state_r == S_LOAD && !held[0].valid))
    else $error("paint did not start with an empty row");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |-> !out_load)
    else $error("output stage overwritten while stalled");

endmodule
